### src/fds_pkg.sv
// Package for the dielectric scatter unit: constants, types and shared arithmetic helpers.
`timescale 1ns / 1ps

package fds_pkg;

	localparam int IOR_W      = 14;
	localparam int COMP_W     = 16;
	localparam int IN_TDATA_W = 112;
	localparam int OUT_TDATA_W = 72;
	localparam int WGT_W      = 17;
	localparam int EV_W       = 2;

	localparam logic [IOR_W-1:0] IOR_ONE   = 14'd4096;
	localparam logic [IOR_W-1:0] IOR_RESET = 14'd6144;
	// round(2^20 / 1.5) and the Schlick R0 for n = 1.5, Q0.16
	localparam logic [20:0] ETA_IN_RESET = 21'd699051;
	localparam logic [16:0] R0_RESET     = 17'd2621;

	localparam logic [16:0] ONE16   = 17'h10000;
	localparam logic signed [35:0] ONE28 = 36'sd268435456;
	localparam logic signed [21:0] DIR_MAX = 22'sd16384;

	localparam int SQ_STAGES = 15;

	typedef enum logic [EV_W-1:0] {
		EV_TIR  = 2'd0,
		EV_REFL = 2'd1,
		EV_REFR = 2'd2
	} event_t;

	// Square-root stage: partial remainder, root so far, radicand bits still to shift in
	typedef struct packed {
		logic [33:0] rem;
		logic [29:0] root;
		logic [59:0] rad;
	} sq_t;

	// Values carried alongside the square root
	typedef struct packed {
		logic               into;
		logic               tir;
		logic signed [29:0] dc;
		logic [15:0]        rnd;
		logic [2:0][15:0]   nn;
		logic [2:0][16:0]   n;
		logic [2:0][32:0]   mir;
		logic [2:0][33:0]   a;
	} carry_t;

	// Values carried through the Schlick power chain
	typedef struct packed {
		logic             tir;
		logic [15:0]      rnd;
		logic [2:0][32:0] mir;
		logic [2:0][34:0] wt;
	} tail_t;

	// Right shift, round to nearest, ties away from zero
	function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int unsigned s);
		logic [63:0] m;
		logic [63:0] h;
		m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
		h = 64'd1 << (s - 1);
		m = (m + h) >> s;
		return v[63] ? $signed(64'd0 - m) : $signed(m);
	endfunction

	// Two digits of the restoring integer square root
	function automatic sq_t sq_step(input sq_t i);
		sq_t o;
		logic [33:0] trial;
		o = i;
		for (int k = 0; k < 2; k++) begin
			o.rem = {o.rem[31:0], o.rad[59:58]};
			o.rad = {o.rad[57:0], 2'b00};
			trial = {2'b00, o.root, 2'b01};
			if (o.rem >= trial) begin
				o.rem  = o.rem - trial;
				o.root = {o.root[28:0], 1'b1};
			end else begin
				o.root = {o.root[28:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage

### src/fresnel_dielectric_scatter_unit.sv
// Dielectric scatter unit: Snell refraction with Schlick Fresnel choice, fully pipelined.
`timescale 1ns / 1ps

// 31 register stages, from the stage 1 input registers to the stage 31 output register.
// Throughput: one item per cycle while the divider is idle; a master-side stall freezes the whole pipeline in place.
// A write to the index register starts a shared bit-serial divider (two 45-step passes)
// that forms 1/n and R0; s_tready stays low until it is done.
// Reset (arst_n low, asynchronous): pipeline empty, index 1.5 with its derived constants.
module fresnel_dielectric_scatter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fds_pkg::IOR_W-1:0]      cfg_wdata,   // index_of_refraction, Q2.12
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// ray_dir_x, ray_dir_y, ray_dir_z, normal_x, normal_y, normal_z, random_fraction
	input  logic [fds_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_dir_x, out_dir_y, out_dir_z, path_weight, zero pad
	output logic [fds_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [fds_pkg::EV_W-1:0]       m_tuser     // event_res
);
	import fds_pkg::*;

	// ------------------------------------------------------------------
	// Index register and the divider that derives 1/n (Q.20) and R0 (Q0.16)
	// ------------------------------------------------------------------
	logic [IOR_W-1:0] ior_q;
	logic             busy_q, load_q, div_ph_q;
	logic [5:0]       div_cnt_q;
	logic [44:0]      div_num_q, div_quo_q;
	logic [29:0]      div_rem_q;
	logic [20:0]      eta_in_q;
	logic [16:0]      r0_q;

	logic [IOR_W-1:0] ior_eff, dm;
	logic [14:0]      sumv;
	logic [29:0]      den, div_d, rem_sh;
	logic [44:0]      num0, num1, quo_nx;
	logic             div_ge;

	assign ior_eff = (ior_q < IOR_ONE) ? IOR_ONE : ior_q;
	assign dm      = ior_eff - IOR_ONE;
	assign sumv    = 15'(ior_eff) + 15'(IOR_ONE);
	assign den     = 30'(sumv) * 30'(sumv);
	assign num0    = (45'd1 << 32) + 45'(ior_eff >> 1);
	assign num1    = (45'(28'(dm) * 28'(dm)) << 16) + 45'(den >> 1);
	assign div_d   = div_ph_q ? den : 30'(ior_eff);
	assign rem_sh  = {div_rem_q[28:0], div_num_q[44]};
	assign div_ge  = rem_sh >= div_d;
	assign quo_nx  = {div_quo_q[43:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ior_q     <= IOR_RESET;
			busy_q    <= 1'b0;
			load_q    <= 1'b0;
			div_ph_q  <= 1'b0;
			div_cnt_q <= '0;
			eta_in_q  <= ETA_IN_RESET;
			r0_q      <= R0_RESET;
		end else if (cfg_we) begin
			ior_q    <= cfg_wdata;
			busy_q   <= 1'b1;
			load_q   <= 1'b1;
			div_ph_q <= 1'b0;
		end else if (busy_q) begin
			if (load_q) begin
				load_q    <= 1'b0;
				div_cnt_q <= 6'd44;
			end else if (div_cnt_q == 6'd0) begin
				if (!div_ph_q) begin
					eta_in_q <= quo_nx[20:0];
					div_ph_q <= 1'b1;
					load_q   <= 1'b1;
				end else begin
					r0_q   <= quo_nx[16:0];
					busy_q <= 1'b0;
				end
			end else begin
				div_cnt_q <= div_cnt_q - 6'd1;
			end
		end
	end

	// divider datapath: one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (busy_q && load_q) begin
			div_num_q <= div_ph_q ? num1 : num0;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (busy_q) begin
			div_num_q <= {div_num_q[43:0], 1'b0};
			div_rem_q <= div_ge ? (rem_sh - div_d) : rem_sh;
			div_quo_q <= quo_nx;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: everything moves together unless the output is held
	// ------------------------------------------------------------------
	logic en, s_acc;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_sq [SQ_STAGES];
	logic v_s22, v_s23, v_s24, v_s25, v_s26, v_s27, v_s28, v_s29, v_s30, v_s31;

	assign en       = !v_s31 || m_tready;
	assign s_tready = en && !busy_q;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			for (int k = 0; k < SQ_STAGES; k++) v_sq[k] <= 1'b0;
			v_s22 <= 1'b0; v_s23 <= 1'b0; v_s24 <= 1'b0; v_s25 <= 1'b0; v_s26 <= 1'b0;
			v_s27 <= 1'b0; v_s28 <= 1'b0; v_s29 <= 1'b0; v_s30 <= 1'b0; v_s31 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_acc; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			v_sq[0] <= v_s6;
			for (int k = 1; k < SQ_STAGES; k++) v_sq[k] <= v_sq[k-1];
			v_s22 <= v_sq[SQ_STAGES-1];
			v_s23 <= v_s22; v_s24 <= v_s23; v_s25 <= v_s24; v_s26 <= v_s25;
			v_s27 <= v_s26; v_s28 <= v_s27; v_s29 <= v_s28; v_s30 <= v_s29; v_s31 <= v_s30;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: wi = -ray, wi.N partial products
	// ------------------------------------------------------------------
	logic signed [16:0] wi_in [3];
	logic signed [15:0] nn_in [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wi_in[i] = 17'sd0 - 17'($signed(s_tdata[i*COMP_W +: COMP_W]));
			nn_in[i] = $signed(s_tdata[(3+i)*COMP_W +: COMP_W]);
		end
	end

	logic signed [16:0] wi_s1 [3];
	logic signed [15:0] nn_s1 [3];
	logic signed [32:0] p_s1 [3];
	logic [15:0]        rnd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				wi_s1[i] <= wi_in[i];
				nn_s1[i] <= nn_in[i];
				p_s1[i]  <= 33'(wi_in[i]) * 33'(nn_in[i]);
			end
			rnd_s1 <= s_tdata[6*COMP_W +: COMP_W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: cosine, side of the surface, eta, oriented normal
	// ------------------------------------------------------------------
	logic signed [34:0] d_c;
	logic               into_c;
	logic signed [29:0] dc_c;

	assign d_c    = 35'(p_s1[0]) + 35'(p_s1[1]) + 35'(p_s1[2]);
	assign into_c = d_c > 35'sd0;
	always_comb begin
		if (d_c > 35'(ONE28))       dc_c = 30'(ONE28);
		else if (d_c < -35'(ONE28)) dc_c = -30'(ONE28);
		else                        dc_c = 30'(d_c);
	end

	logic               into_s2;
	logic signed [29:0] dc_s2, t_s2;
	logic signed [23:0] eta_s2;
	logic signed [16:0] wi_s2 [3];
	logic signed [15:0] nn_s2 [3];
	logic signed [16:0] n_s2 [3];
	logic [15:0]        rnd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			into_s2 <= into_c;
			dc_s2   <= dc_c;
			t_s2    <= into_c ? dc_c : -dc_c;
			eta_s2  <= into_c ? $signed(24'(eta_in_q)) : $signed(24'({ior_eff, 8'd0}));
			for (int i = 0; i < 3; i++) begin
				wi_s2[i] <= wi_s1[i];
				nn_s2[i] <= nn_s1[i];
				n_s2[i]  <= into_c ? 17'(nn_s1[i]) : -17'(nn_s1[i]);
			end
			rnd_s2 <= rnd_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: squares and the normal products
	// ------------------------------------------------------------------
	logic               into_s3;
	logic signed [29:0] dc_s3;
	logic signed [59:0] tt_s3;
	logic signed [47:0] ee_s3;
	logic signed [23:0] eta_s3;
	logic signed [45:0] mdc_s3 [3];
	logic signed [46:0] nt_s3 [3];
	logic signed [16:0] wi_s3 [3];
	logic signed [15:0] nn_s3 [3];
	logic signed [16:0] n_s3 [3];
	logic [15:0]        rnd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			into_s3 <= into_s2;
			dc_s3   <= dc_s2;
			tt_s3   <= 60'(t_s2) * 60'(t_s2);
			ee_s3   <= 48'(eta_s2) * 48'(eta_s2);
			eta_s3  <= eta_s2;
			for (int i = 0; i < 3; i++) begin
				mdc_s3[i] <= 46'(nn_s2[i]) * 46'(dc_s2);
				nt_s3[i]  <= 47'(n_s2[i]) * 47'(t_s2);
				wi_s3[i]  <= wi_s2[i];
				nn_s3[i]  <= nn_s2[i];
				n_s3[i]   <= n_s2[i];
			end
			rnd_s3 <= rnd_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: 1 - t^2, eta^2, mirror direction, (n t - wi)
	// ------------------------------------------------------------------
	logic               into_s4;
	logic signed [29:0] dc_s4, s_s4;
	logic signed [25:0] e2_s4;
	logic signed [23:0] eta_s4;
	logic signed [32:0] mir_s4 [3];
	logic signed [32:0] q_s4 [3];
	logic signed [15:0] nn_s4 [3];
	logic signed [16:0] n_s4 [3];
	logic [15:0]        rnd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			into_s4 <= into_s3;
			dc_s4   <= dc_s3;
			s_s4    <= 30'(ONE28) - 30'(rshr(64'(tt_s3), 28));
			e2_s4   <= 26'(rshr(64'(ee_s3), 20));
			eta_s4  <= eta_s3;
			for (int i = 0; i < 3; i++) begin
				mir_s4[i] <= (33'(rshr(64'(mdc_s3[i]), 14)) <<< 1)
				             - 33'($signed({wi_s3[i], 14'd0}));
				q_s4[i]   <= 33'(rshr(64'(nt_s3[i]), 14)) - 33'($signed({wi_s3[i], 14'd0}));
				nn_s4[i]  <= nn_s3[i];
				n_s4[i]   <= n_s3[i];
			end
			rnd_s4 <= rnd_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: eta^2 (1 - t^2) and eta (n t - wi)
	// ------------------------------------------------------------------
	logic               into_s5;
	logic signed [29:0] dc_s5;
	logic signed [55:0] es_s5;
	logic signed [56:0] qe_s5 [3];
	logic signed [32:0] mir_s5 [3];
	logic signed [15:0] nn_s5 [3];
	logic signed [16:0] n_s5 [3];
	logic [15:0]        rnd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			into_s5 <= into_s4;
			dc_s5   <= dc_s4;
			es_s5   <= 56'(e2_s4) * 56'(s_s4);
			for (int i = 0; i < 3; i++) begin
				qe_s5[i]  <= 57'(q_s4[i]) * 57'(eta_s4);
				mir_s5[i] <= mir_s4[i];
				nn_s5[i]  <= nn_s4[i];
				n_s5[i]   <= n_s4[i];
			end
			rnd_s5 <= rnd_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: discriminant, TIR flag, radicand for the square root
	// ------------------------------------------------------------------
	logic signed [35:0] t2_c;
	logic               tir_c;
	carry_t             cy_c;
	sq_t                sq_c;

	assign t2_c  = ONE28 - 36'(rshr(64'(es_s5), 20));
	assign tir_c = t2_c < 36'sd0;

	always_comb begin
		cy_c.into = into_s5;
		cy_c.tir  = tir_c;
		cy_c.dc   = dc_s5;
		cy_c.rnd  = rnd_s5;
		for (int i = 0; i < 3; i++) begin
			cy_c.nn[i]  = nn_s5[i];
			cy_c.n[i]   = n_s5[i];
			cy_c.mir[i] = mir_s5[i];
			cy_c.a[i]   = 34'(rshr(64'(qe_s5[i]), 20));
		end
		sq_c.rem  = '0;
		sq_c.root = '0;
		sq_c.rad  = tir_c ? 60'd0 : {3'b000, t2_c[28:0], 28'd0};
	end

	carry_t cy_s6;
	sq_t    sq_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			cy_s6 <= cy_c;
			sq_s6 <= sq_c;
		end
	end

	// ------------------------------------------------------------------
	// Stages 7..21: floor sqrt(t2 * 2^28), two root bits a stage
	// ------------------------------------------------------------------
	sq_t    sq_s [SQ_STAGES];
	carry_t cy_sq [SQ_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0]  <= sq_step(sq_s6);
			cy_sq[0] <= cy_s6;
			for (int k = 1; k < SQ_STAGES; k++) begin
				sq_s[k]  <= sq_step(sq_s[k-1]);
				cy_sq[k] <= cy_sq[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 22..24: transmitted direction and its cosine products
	// ------------------------------------------------------------------
	logic signed [47:0] nr_s22 [3];
	carry_t             cy_s22, cy_s23, cy_s24;
	logic signed [34:0] wt_s23 [3];
	logic signed [34:0] wt_s24 [3];
	logic signed [50:0] wtn_s24 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			cy_s22 <= cy_sq[SQ_STAGES-1];
			for (int i = 0; i < 3; i++)
				nr_s22[i] <= 48'($signed(cy_sq[SQ_STAGES-1].n[i]))
				             * 48'($signed({1'b0, sq_s[SQ_STAGES-1].root}));
			cy_s23 <= cy_s22;
			for (int i = 0; i < 3; i++)
				wt_s23[i] <= 35'($signed(cy_s22.a[i])) - 35'(rshr(64'(nr_s22[i]), 14));
			cy_s24 <= cy_s23;
			for (int i = 0; i < 3; i++) begin
				wt_s24[i]  <= wt_s23[i];
				wtn_s24[i] <= 51'(wt_s23[i]) * 51'($signed(cy_s23.nn[i]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 25: Schlick cosine, x = 1 - cos
	// ------------------------------------------------------------------
	logic signed [52:0] acc_c;
	logic signed [38:0] cos_c;
	logic [28:0]        cosk_c;
	logic [16:0]        c16_c;
	tail_t              tl_c;

	always_comb begin
		acc_c = 53'(wtn_s24[0]) + 53'(wtn_s24[1]) + 53'(wtn_s24[2]);
		cos_c = cy_s24.into ? 39'(cy_s24.dc) : 39'(rshr(64'(acc_c), 14));
		if (cos_c < 39'sd0)               cosk_c = '0;
		else if (cos_c > 39'(ONE28))      cosk_c = 29'(ONE28);
		else                              cosk_c = 29'(cos_c);
		c16_c = 17'((30'(cosk_c) + 30'd2048) >> 12);
		tl_c.tir = cy_s24.tir;
		tl_c.rnd = cy_s24.rnd;
		for (int i = 0; i < 3; i++) begin
			tl_c.mir[i] = cy_s24.mir[i];
			tl_c.wt[i]  = wt_s24[i];
		end
	end

	// ------------------------------------------------------------------
	// Stages 25..30: x^5 by four rounded products, then (1 - R0) x^5
	// ------------------------------------------------------------------
	logic [16:0] x_s25, x_s26, x_s27, x_s28;
	logic [16:0] p_s26, p_s27, p_s28, p_s29;
	logic [33:0] kp_s30;
	tail_t       tl_s25, tl_s26, tl_s27, tl_s28, tl_s29, tl_s30;

	function automatic logic [16:0] mulq16(input logic [16:0] a, input logic [16:0] b);
		logic [33:0] pr;
		pr = 34'(a) * 34'(b);
		return 17'((pr + 34'd32768) >> 16);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			x_s25  <= ONE16 - c16_c;
			tl_s25 <= tl_c;
			x_s26  <= x_s25;
			p_s26  <= mulq16(x_s25, x_s25);
			tl_s26 <= tl_s25;
			x_s27  <= x_s26;
			p_s27  <= mulq16(p_s26, x_s26);
			tl_s27 <= tl_s26;
			x_s28  <= x_s27;
			p_s28  <= mulq16(p_s27, x_s27);
			tl_s28 <= tl_s27;
			p_s29  <= mulq16(p_s28, x_s28);
			tl_s29 <= tl_s28;
			kp_s30 <= 34'(ONE16 - r0_q) * 34'(p_s29);
			tl_s30 <= tl_s29;
		end
	end

	// ------------------------------------------------------------------
	// Stage 31: Fresnel choice, output rounding and saturation (output register)
	// ------------------------------------------------------------------
	logic [17:0]        fr_raw;
	logic [16:0]        fr_c;
	logic               refl_c;
	logic signed [34:0] dsel_c [3];
	logic signed [21:0] dr_c [3];
	logic [15:0]        do_c [3];

	always_comb begin
		fr_raw = 18'(r0_q) + 18'((kp_s30 + 34'd32768) >> 16);
		fr_c   = (fr_raw > 18'(ONE16)) ? ONE16 : fr_raw[16:0];
		refl_c = tl_s30.tir || (17'(tl_s30.rnd) < fr_c);
		for (int i = 0; i < 3; i++) begin
			dsel_c[i] = refl_c ? 35'($signed(tl_s30.mir[i])) : $signed(tl_s30.wt[i]);
			dr_c[i]   = 22'(rshr(64'(dsel_c[i]), 14));
			if (dr_c[i] > DIR_MAX)       do_c[i] = 16'(DIR_MAX);
			else if (dr_c[i] < -DIR_MAX) do_c[i] = 16'(-DIR_MAX);
			else                         do_c[i] = 16'(dr_c[i]);
		end
	end

	logic [15:0]      dir_s31 [3];
	logic [WGT_W-1:0] wgt_s31;
	event_t           ev_s31;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) dir_s31[i] <= do_c[i];
			if (tl_s30.tir) begin
				wgt_s31 <= ONE16;
				ev_s31  <= EV_TIR;
			end else if (refl_c) begin
				wgt_s31 <= fr_c;
				ev_s31  <= EV_REFL;
			end else begin
				wgt_s31 <= ONE16 - fr_c;
				ev_s31  <= EV_REFR;
			end
		end
	end

	assign m_tvalid = v_s31;
	assign m_tdata  = {7'd0, wgt_s31, dir_s31[2], dir_s31[1], dir_s31[0]};
	assign m_tuser  = ev_s31;

`ifndef SYNTHESIS
	// divider recomputation blocks intake
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready) else $error("item taken while divider busy");

	// a register write always starts the divider
	a_cfg_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy_q) else $error("config write did not start divider");

	// total internal reflection carries full weight
	a_tir_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_TIR) |-> (m_tdata[64:48] == ONE16))
		else $error("TIR weight not one");

	// weight never exceeds one
	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[64:48] <= ONE16)) else $error("weight above one");
`endif

endmodule
